>>> src/json_string_unescaper_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the JSON string unescaper
// Shared helpers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_DEFINES_SVH
`define JSON_STRING_UNESCAPER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define JSU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once true, implies another one in the next cycle.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the parts of the JSON string unescaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One decoded unit: one to three result items.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] n;
    kind_t      kind;
  } unit_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] CAPACITY_RESET = 16'd64;

endpackage

>>> src/json_string_unescaper.sv
// Decoded units pass through a queue slot and then the output register to the ports.
// One input item per cycle while the queue is not full; a \u escape that decodes
// to two or three bytes leaves the single output register one byte after another, and
// a four-unit queue absorbs such bursts. Reset clears the decode state, the queue and
// the output valid flag at once, and sets capacity to 64.
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes JSON string bodies to UTF-8 with an APB-style capacity register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_unescaper #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic        last
);
  import jsu_pkg::*;

  logic [15:0] capacity;
  logic        accept;
  logic        unit_push;
  unit_t       unit_data;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  unit_t       q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'h0000, capacity} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      capacity <= pwdata[15:0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  jsu_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .in_byte   (in_byte),
    .capacity  (capacity),
    .unit_push (unit_push),
    .unit_data (unit_data)
  );

  jsu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (unit_push),
    .wr_data (unit_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_valid (q_valid),
    .rd_data (q_data)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .kind     (kind),
    .last     (last)
  );

endmodule

>>> src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts input items, tracks escape state and output count, and produces
// one decoded unit per item that causes results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          op,
  input  logic [7:0]    in_byte,
  input  logic [15:0]   capacity,
  output logic          unit_push,
  output jsu_pkg::unit_t unit_data
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_ESC    = 3'd1,
    M_HEX0   = 3'd2,
    M_HEX1   = 3'd3,
    M_HEX2   = 3'd4,
    M_HEX3   = 3'd5
  } mode_t;

  localparam int TW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
  localparam logic [TW-1:0] CMAX = {{(TW - COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  mode_t                  mode, mode_next;
  logic [15:0]            code_point, code_point_next;
  logic [COUNT_WIDTH-1:0] out_count, out_count_next;
  logic                   error_seen, error_seen_next;

  logic [7:0]    esc_byte;
  logic          esc_ok;
  logic [3:0]    hex_val;
  logic          hex_ok;
  logic [15:0]   cp_new;
  unit_t         hex_unit;
  logic [1:0]    unit_len;
  logic [TW-1:0] total;
  logic          fits;
  logic          end_bad;
  unit_t         unit_c;
  logic          push_c;

  always_comb begin
    esc_ok = 1'b1;
    case (in_byte)
      CH_QUOTE:  esc_byte = CH_QUOTE;
      CH_BSLASH: esc_byte = CH_BSLASH;
      CH_SLASH:  esc_byte = CH_SLASH;
      8'h62:     esc_byte = 8'h08;
      8'h66:     esc_byte = 8'h0C;
      8'h6E:     esc_byte = 8'h0A;
      8'h72:     esc_byte = 8'h0D;
      8'h74:     esc_byte = 8'h09;
      default: begin
        esc_byte = 8'h00;
        esc_ok   = 1'b0;
      end
    endcase
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_new = {code_point[11:0], hex_val};

  always_comb begin
    hex_unit.kind = KIND_DATA;
    if (cp_new[15:11] == 5'b11011) begin
      hex_unit.n  = 2'd3;
      hex_unit.b0 = 8'hEF;
      hex_unit.b1 = 8'hBF;
      hex_unit.b2 = 8'hBD;
    end else if (cp_new[15:7] == 9'd0) begin
      hex_unit.n  = 2'd1;
      hex_unit.b0 = {1'b0, cp_new[6:0]};
      hex_unit.b1 = 8'h00;
      hex_unit.b2 = 8'h00;
    end else if (cp_new[15:11] == 5'd0) begin
      hex_unit.n  = 2'd2;
      hex_unit.b0 = 8'hC0 | {3'b000, cp_new[10:6]};
      hex_unit.b1 = 8'h80 | {2'b00, cp_new[5:0]};
      hex_unit.b2 = 8'h00;
    end else begin
      hex_unit.n  = 2'd3;
      hex_unit.b0 = 8'hE0 | {4'b0000, cp_new[15:12]};
      hex_unit.b1 = 8'h80 | {2'b00, cp_new[11:6]};
      hex_unit.b2 = 8'h80 | {2'b00, cp_new[5:0]};
    end
  end

  assign unit_len = (mode == M_HEX3) ? hex_unit.n : 2'd1;
  assign total    = {{(TW - COUNT_WIDTH){1'b0}}, out_count} + {{(TW - 2){1'b0}}, unit_len};
  assign fits     = (total < {{(TW - 16){1'b0}}, capacity}) && (total <= CMAX);
  assign end_bad  = error_seen || (mode != M_NORMAL) ||
                    ({{(TW - COUNT_WIDTH){1'b0}}, out_count} >= {{(TW - 16){1'b0}}, capacity});

  always_comb begin
    mode_next       = mode;
    code_point_next = code_point;
    out_count_next  = out_count;
    error_seen_next = error_seen;
    push_c          = 1'b0;
    unit_c          = '{b0: 8'h00, b1: 8'h00, b2: 8'h00, n: 2'd1, kind: KIND_ERR};
    if (accept) begin
      if (op) begin
        push_c          = 1'b1;
        unit_c.kind     = end_bad ? KIND_ERR : KIND_OK;
        mode_next       = M_NORMAL;
        code_point_next = 16'd0;
        out_count_next  = '0;
        error_seen_next = 1'b0;
      end else if (!error_seen) begin
        case (mode)
          M_ESC: begin
            if (in_byte == CH_U) begin
              mode_next       = M_HEX0;
              code_point_next = 16'd0;
            end else if (esc_ok && fits) begin
              mode_next      = M_NORMAL;
              push_c         = 1'b1;
              unit_c.kind    = KIND_DATA;
              unit_c.b0      = esc_byte;
              out_count_next = out_count + COUNT_WIDTH'(1);
            end else begin
              error_seen_next = 1'b1;
              mode_next       = M_NORMAL;
              push_c          = 1'b1;
            end
          end
          M_HEX0, M_HEX1, M_HEX2: begin
            if (hex_ok) begin
              code_point_next = cp_new;
              mode_next       = mode_t'(mode + 3'd1);
            end else begin
              error_seen_next = 1'b1;
              mode_next       = M_NORMAL;
              push_c          = 1'b1;
            end
          end
          M_HEX3: begin
            mode_next = M_NORMAL;
            push_c    = 1'b1;
            if (hex_ok) begin
              code_point_next = cp_new;
            end
            if (hex_ok && fits) begin
              unit_c         = hex_unit;
              out_count_next = out_count + COUNT_WIDTH'(hex_unit.n);
            end else begin
              error_seen_next = 1'b1;
            end
          end
          default: begin
            mode_next = M_NORMAL;
            if (in_byte == CH_BSLASH) begin
              mode_next = M_ESC;
            end else if (fits) begin
              push_c         = 1'b1;
              unit_c.kind    = KIND_DATA;
              unit_c.b0      = in_byte;
              out_count_next = out_count + COUNT_WIDTH'(1);
            end else begin
              error_seen_next = 1'b1;
              push_c          = 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign unit_push = push_c;
  assign unit_data = unit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      code_point <= 16'd0;
      out_count  <= '0;
      error_seen <= 1'b0;
    end else begin
      mode       <= mode_next;
      code_point <= code_point_next;
      out_count  <= out_count_next;
      error_seen <= error_seen_next;
    end
  end

endmodule

>>> src/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short queue of decoded units between the front and the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  jsu_pkg::unit_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_valid,
  output jsu_pkg::unit_t rd_data
);
  import jsu_pkg::*;

  unit_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr_en && !q_full) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en && !q_full) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (rd_en && q_valid) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({wr_en && !q_full, rd_en && q_valid})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializes queued units into result items through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_unescaper_defines.svh"

module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  jsu_pkg::unit_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic [1:0]     kind,
  output logic           last
);
  import jsu_pkg::*;

  logic       out_valid;
  logic [1:0] idx;
  logic [7:0] sel_byte;
  logic       sel_last;
  logic       load;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = q_data.b0;
      2'd1:    sel_byte = q_data.b1;
      2'd2:    sel_byte = q_data.b2;
      default: sel_byte = 8'h00;
    endcase
  end

  assign sel_last = (idx == (q_data.n - 2'd1));
  assign load     = q_valid && (!out_valid || pop);
  assign q_pop    = load && sel_last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= sel_last ? 2'd0 : idx + 2'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      kind     <= q_data.kind;
      last     <= sel_last;
    end
  end

  `JSU_ASSERT_ALWAYS(a_idx_in_unit, !q_valid || (idx < q_data.n), "byte index past unit")
  `JSU_ASSERT_ALWAYS(a_unit_nonempty, !q_valid || (q_data.n != 2'd0), "empty unit queued")
  `JSU_ASSERT_ALWAYS(a_status_is_last, !out_valid || (kind == KIND_DATA) || last,
                     "status item without last")
  `JSU_ASSERT_NEXT(a_unit_continues, load && !sel_last, q_valid && (idx != 2'd0),
                   "unit left before its last item")

endmodule
